>>> rtl/srecord_stream_parser_defines.svh
// Assertion macros for the S-record stream parser.
// Used by srecord_stream_parser.sv; expects clk and rst_n in scope.
`ifndef SRECORD_STREAM_PARSER_DEFINES_SVH
`define SRECORD_STREAM_PARSER_DEFINES_SVH

// same-cycle implication
`define SRP_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SRP_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/srp_pkg.sv
// Package for the S-record stream parser: event and phase codes,
// character constants and character decode helpers. No dependencies.
`timescale 1ns / 1ps

package srp_pkg;

  localparam int CharW  = 8;
  localparam int EventW = 2;
  localparam int SpaceW = 3;
  localparam int AddrW  = 32;
  localparam int DataW  = 8;
  localparam int PhaseW = 3;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [EventW-1:0] event_t;
  typedef logic [PhaseW-1:0] phase_t;

  localparam event_t EV_WRITE = 2'd0;
  localparam event_t EV_ERROR = 2'd1;
  localparam event_t EV_EOF   = 2'd2;

  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_TYPE  = 3'd1;
  localparam phase_t PH_COUNT = 3'd2;
  localparam phase_t PH_ADDR  = 3'd3;
  localparam phase_t PH_DATA  = 3'd4;
  localparam phase_t PH_SKIP  = 3'd5;

  localparam char_t CH_S = 8'h53;
  localparam char_t CH_1 = 8'h31;
  localparam char_t CH_2 = 8'h32;
  localparam char_t CH_3 = 8'h33;
  localparam char_t CH_7 = 8'h37;
  localparam char_t CH_8 = 8'h38;
  localparam char_t CH_9 = 8'h39;

  function automatic logic is_blank(input char_t c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_value(input char_t c);
    logic [3:0] v;
    v = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c[3:0];
    end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

>>> rtl/srecord_stream_parser.sv
// Top level of the S-record stream parser: character decode, record state
// and registered result word. Depends on srp_pkg and srecord_stream_parser_defines.svh.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+-----------------------
//   input   | in_char_code                        | in_valid / in_ready
//   result  | out_event_res, out_space_index,     | out_valid / out_ready
//           | out_write_address, out_write_data   |
//   config  | cfg_wr_data                         | cfg_wr_en, no wait
//
// One character word per cycle while in_ready; a result shows the cycle after accept.
// The output register sets the rate: in_ready is high while it is empty or being taken.
// Synchronous active-low reset clears record state, target space and out_valid.
// After a format error or end-of-file record, words are accepted and dropped until reset.
`timescale 1ns / 1ps
`include "srecord_stream_parser_defines.svh"

module srecord_stream_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srp_pkg::CharW-1:0]    in_char_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [srp_pkg::EventW-1:0]   out_event_res,
  output logic [srp_pkg::SpaceW-1:0]   out_space_index,
  output logic [srp_pkg::AddrW-1:0]    out_write_address,
  output logic [srp_pkg::DataW-1:0]    out_write_data,
  input  logic                         cfg_wr_en,
  input  logic [srp_pkg::SpaceW-1:0]   cfg_wr_data
);

  logic [srp_pkg::SpaceW-1:0] space_r;

  srp_pkg::phase_t            phase_r, phase_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [3:0]                 digit_r, digit_nxt;
  logic [7:0]                 count_r, count_nxt;
  logic [srp_pkg::AddrW-1:0]  base_r, base_nxt;
  logic [7:0]                 index_r, index_nxt;
  logic [3:0]                 high_r, high_nxt;
  logic                       stopped_r, stopped_nxt;

  logic                       out_valid_r, out_valid_nxt;
  srp_pkg::event_t            ev_r, ev_nxt;
  logic [srp_pkg::SpaceW-1:0] sp_r, sp_nxt;
  logic [srp_pkg::AddrW-1:0]  addr_r, addr_nxt;
  logic [srp_pkg::DataW-1:0]  data_r, data_nxt;

  logic       accept;
  logic       emit;
  logic [3:0] nib;
  logic [2:0] overhead;
  logic [7:0] data_len;
  logic [3:0] addr_digits;
  logic [3:0] digit_inc;
  logic [7:0] index_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign nib      = srp_pkg::hex_value(in_char_code);

  assign overhead    = {1'b0, kind_r} + 3'd2;
  assign data_len    = (count_r > {5'd0, overhead}) ? (count_r - {5'd0, overhead}) : 8'd0;
  assign addr_digits = {1'b0, kind_r, 1'b0} + 4'd2;
  assign digit_inc   = digit_r + 4'd1;
  assign index_inc   = index_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    digit_nxt   = digit_r;
    count_nxt   = count_r;
    base_nxt    = base_r;
    index_nxt   = index_r;
    high_nxt    = high_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    ev_nxt      = srp_pkg::EV_WRITE;
    sp_nxt      = '0;
    addr_nxt    = '0;
    data_nxt    = '0;
    if (accept && !stopped_r) begin
      if (srp_pkg::is_blank(in_char_code)) begin
        phase_nxt = srp_pkg::PH_IDLE;
      end else begin
        unique case (phase_r)
          srp_pkg::PH_IDLE: begin
            if (in_char_code != srp_pkg::CH_S) begin
              stopped_nxt = 1'b1;
              emit        = 1'b1;
              ev_nxt      = srp_pkg::EV_ERROR;
            end else begin
              phase_nxt = srp_pkg::PH_TYPE;
            end
          end
          srp_pkg::PH_TYPE: begin
            if ((in_char_code == srp_pkg::CH_1) || (in_char_code == srp_pkg::CH_2) ||
                (in_char_code == srp_pkg::CH_3)) begin
              kind_nxt  = in_char_code[1:0];
              phase_nxt = srp_pkg::PH_COUNT;
              digit_nxt = 4'd0;
              count_nxt = 8'd0;
              base_nxt  = '0;
              index_nxt = 8'd0;
            end else if ((in_char_code == srp_pkg::CH_7) || (in_char_code == srp_pkg::CH_8) ||
                         (in_char_code == srp_pkg::CH_9)) begin
              stopped_nxt = 1'b1;
              emit        = 1'b1;
              ev_nxt      = srp_pkg::EV_EOF;
            end else begin
              phase_nxt = srp_pkg::PH_SKIP;
            end
          end
          srp_pkg::PH_COUNT: begin
            count_nxt = {count_r[3:0], nib};
            if (digit_inc >= 4'd2) begin
              digit_nxt = 4'd0;
              phase_nxt = srp_pkg::PH_ADDR;
            end else begin
              digit_nxt = digit_inc;
            end
          end
          srp_pkg::PH_ADDR: begin
            base_nxt = {base_r[srp_pkg::AddrW-5:0], nib};
            if (digit_inc >= addr_digits) begin
              digit_nxt = 4'd0;
              phase_nxt = (data_len != 8'd0) ? srp_pkg::PH_DATA : srp_pkg::PH_SKIP;
            end else begin
              digit_nxt = digit_inc;
            end
          end
          srp_pkg::PH_DATA: begin
            if (digit_r == 4'd0) begin
              high_nxt  = nib;
              digit_nxt = 4'd1;
            end else begin
              digit_nxt = 4'd0;
              index_nxt = index_inc;
              if (index_inc >= data_len) begin
                phase_nxt = srp_pkg::PH_SKIP;
              end
              emit     = 1'b1;
              ev_nxt   = srp_pkg::EV_WRITE;
              sp_nxt   = space_r;
              addr_nxt = base_r + {{(srp_pkg::AddrW-8){1'b0}}, index_r};
              data_nxt = {high_r, nib};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r     <= '0;
      phase_r     <= srp_pkg::PH_IDLE;
      kind_r      <= 2'd0;
      digit_r     <= 4'd0;
      count_r     <= 8'd0;
      base_r      <= '0;
      index_r     <= 8'd0;
      high_r      <= 4'd0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        space_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      digit_r     <= digit_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      index_r     <= index_nxt;
      high_r      <= high_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      ev_r   <= ev_nxt;
      sp_r   <= sp_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_space_index   = sp_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;

  `SRP_ASSERT_NXT(a_stop_sticky, stopped_r, stopped_r, "parser left stopped state without reset")
  `SRP_ASSERT_IMP(a_data_in_range, phase_r == srp_pkg::PH_DATA, index_r < data_len,
                  "data phase past record length")
  `SRP_ASSERT_IMP(a_event_stops,
                  out_valid_r && ((ev_r == srp_pkg::EV_ERROR) || (ev_r == srp_pkg::EV_EOF)),
                  stopped_r, "error or eof word without stop")
  `SRP_ASSERT_IMP(a_event_zero, out_valid_r && (ev_r != srp_pkg::EV_WRITE),
                  (sp_r == '0) && (addr_r == '0) && (data_r == '0),
                  "non-write word with nonzero payload")

endmodule
